// ===== rtl/nnpm_pkg.sv =====
package nnpm_pkg;

   localparam int MAX_PARTICLES_DEF = 16;

   localparam int COORD_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int SQ_W       = 32;
   localparam int DIST_W     = SQ_W + 1;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Angle constants in Q3.12, carried one bit wider for the difference math.
   localparam logic [ANGLE_W:0]        HALF_PI_FLIP = 17'd6434;
   localparam logic signed [ANGLE_W:0] PI_Q12       = 17'sd12868;
   localparam logic signed [ANGLE_W:0] ANGLE_MAX    = 17'sd32767;

   typedef enum logic {
      REG_PARTICLE_COUNT = 1'b0,
      REG_ORIENTATION    = 1'b1
   } csr_reg_type;

   // Laid out like the request data, x in the lowest bits.
   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic [COORD_W-1:0]        y;
      logic [COORD_W-1:0]        x;
   } particle_type;

endpackage

// ===== rtl/nnpm_dist.sv =====
module nnpm_dist
   import nnpm_pkg::*;
#(
   parameter int TAG_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic [TAG_W-1:0]   in_tag,
   input  logic [COORD_W-1:0] cur_x,
   input  logic [COORD_W-1:0] cur_y,
   input  logic [COORD_W-1:0] prev_x,
   input  logic [COORD_W-1:0] prev_y,
   output logic               out_vld,
   output logic [TAG_W-1:0]   out_tag,
   output logic [DIST_W-1:0]  out_dist
);

   logic signed [COORD_W:0]     dx;
   logic signed [COORD_W:0]     dy;
   logic signed [2*COORD_W+1:0] dx_sq;
   logic signed [2*COORD_W+1:0] dy_sq;

   logic              sq_vld_ff;
   logic [TAG_W-1:0]  sq_tag_ff;
   logic [SQ_W-1:0]   sq_x_ff;
   logic [SQ_W-1:0]   sq_y_ff;
   logic              sum_vld_ff;
   logic [TAG_W-1:0]  sum_tag_ff;
   logic [DIST_W-1:0] sum_ff;

   always_comb begin
      dx    = $signed({1'b0, cur_x}) - $signed({1'b0, prev_x});
      dy    = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y});
      dx_sq = dx * dx;
      dy_sq = dy * dy;
   end

   // Squares are registered before the sum; both stay below 2^32.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff  <= in_vld;
         sum_vld_ff <= sq_vld_ff;
      end
      sq_tag_ff  <= in_tag;
      sq_x_ff    <= dx_sq[SQ_W-1:0];
      sq_y_ff    <= dy_sq[SQ_W-1:0];
      sum_tag_ff <= sq_tag_ff;
      sum_ff     <= {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   assign out_vld  = sum_vld_ff;
   assign out_tag  = sum_tag_ff;
   assign out_dist = sum_ff;

endmodule

// ===== rtl/nearest_neighbour_particle_matcher.sv =====
// Channel   | Direction | Handshake              | Contents
// req_      | in        | req_tvalid/req_tready  | tdata: pos_x, pos_y, angle; tlast: frame_end
// rsp_      | out       | rsp_tvalid/rsp_tready  | tdata: slot, x, y, angle, conflict; tlast: last
// csr_      | in        | psel/penable, pready=1 | particle_count at 0, orientation_check at 4
//
// A request is taken whenever the sequencer is idle. Closing a first frame copies every
// slot from the current memory to the previous one; a later frame searches through the
// single distance unit, which reads one previous slot per cycle, then updates the matched
// slot of each particle. Reporting does one memory read and one load of the result register
// per slot; a low rsp_tready holds the result and stalls the sequencer.
// Reset clears the control state only; the particle memories hold garbage until written.
module nearest_neighbour_particle_matcher
   import nnpm_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] pos_x, [31:16] pos_y, [47:32] angle
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] slot_index, [19:4] out_x, [35:20] out_y, [51:36] out_angle,
   // [52] match_conflict, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_COPY_RD,
      S_COPY_WR,
      S_SRCH_LD,
      S_SRCH_GO,
      S_SRCH_DRAIN,
      S_UPD_RD,
      S_UPD_SLOT,
      S_UPD_WR,
      S_OUT_RD,
      S_OUT_LD
   } state_type;

   // Memories
   particle_type     cur_mem  [MAX_PARTICLES];
   particle_type     prev_mem [MAX_PARTICLES];
   logic [IDX_W-1:0] near_mem [MAX_PARTICLES];

   particle_type     cur_rd_ff;
   particle_type     prev_rd_ff;
   logic [IDX_W-1:0] near_rd_ff;

   logic             cur_we, cur_re, prev_we, prev_re, near_we, near_re;
   logic [IDX_W-1:0] cur_waddr, cur_raddr, prev_waddr, prev_raddr;
   particle_type     cur_wdata, prev_wdata;
   logic [IDX_W-1:0] near_wdata;

   // Control and datapath registers
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   jdx_ff, jdx_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic               first_ff, first_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               orient_ff, orient_in;
   logic               conflict_ff, conflict_in;
   logic [MAX_PARTICLES-1:0] used_ff, used_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_tag_ff, rd_tag_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               dist_vld;
   logic [IDX_W-1:0]   dist_tag;
   logic [DIST_W-1:0]  dist_sum;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   n_m1;
   logic [IDX_W-1:0]   last_idx;
   logic               req_acc;
   logic               csr_wr;
   logic               take;
   logic [IDX_W-1:0]   win_idx;
   logic               out_load;
   particle_type       req_item;

   logic signed [ANGLE_W:0] a_ext, p_ext, ang_diff, flip_sum;
   logic [ANGLE_W:0]        abs_diff;
   logic signed [ANGLE_W-1:0] new_angle;
   particle_type            upd_item;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_item   = particle_type'(req_tdata);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_reg_type'(csr_paddr[2]))
         REG_PARTICLE_COUNT: csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, count_ff};
         REG_ORIENTATION:    csr_prdata = {{(CSR_DATA_W-1){1'b0}}, orient_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Zero acts as one and values above the memory depth are clipped.
   always_comb begin
      if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_PARTICLES)) begin
         n_eff = CNT_W'(MAX_PARTICLES);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
      n_m1     = n_eff - CNT_W'(1);
      last_idx = n_m1[IDX_W-1:0];
   end

   nnpm_dist #(
      .TAG_W(IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff),
      .in_tag   (rd_tag_ff),
      .cur_x    (cur_rd_ff.x),
      .cur_y    (cur_rd_ff.y),
      .prev_x   (prev_rd_ff.x),
      .prev_y   (prev_rd_ff.y),
      .out_vld  (dist_vld),
      .out_tag  (dist_tag),
      .out_dist (dist_sum)
   );

   // Slot zero seeds the running minimum; a strictly smaller distance replaces it,
   // so ties stay with the lowest slot.
   assign take    = dist_vld && ((dist_tag == '0) || (dist_sum < best_ff));
   assign win_idx = take ? dist_tag : best_idx_ff;

   // Orientation update against the slot's current angle.
   always_comb begin
      a_ext    = {cur_rd_ff.angle[ANGLE_W-1], cur_rd_ff.angle};
      p_ext    = {prev_rd_ff.angle[ANGLE_W-1], prev_rd_ff.angle};
      ang_diff = p_ext - a_ext;
      abs_diff = ang_diff[ANGLE_W] ? unsigned'(-ang_diff) : unsigned'(ang_diff);
      flip_sum = a_ext + PI_Q12;
      if (abs_diff >= HALF_PI_FLIP) begin
         new_angle = (flip_sum > ANGLE_MAX) ? ANGLE_MAX[ANGLE_W-1:0]
                                            : flip_sum[ANGLE_W-1:0];
      end else begin
         new_angle = cur_rd_ff.angle;
      end
      upd_item.x     = cur_rd_ff.x;
      upd_item.y     = cur_rd_ff.y;
      upd_item.angle = orient_ff ? new_angle : prev_rd_ff.angle;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      loaded_in   = loaded_ff;
      first_in    = first_ff;
      count_in    = count_ff;
      orient_in   = orient_ff;
      conflict_in = conflict_ff;
      used_in     = used_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      rd_vld_in   = 1'b0;
      rd_tag_in   = jdx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      out_load    = 1'b0;

      cur_we     = 1'b0;
      cur_waddr  = loaded_ff[IDX_W-1:0];
      cur_wdata  = req_item;
      cur_re     = 1'b0;
      cur_raddr  = idx_ff;
      prev_we    = 1'b0;
      prev_waddr = idx_ff;
      prev_wdata = cur_rd_ff;
      prev_re    = 1'b0;
      prev_raddr = idx_ff;
      near_we    = 1'b0;
      near_wdata = win_idx;
      near_re    = 1'b0;

      if (dist_vld) begin
         best_in     = take ? dist_sum : best_ff;
         best_idx_in = win_idx;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (loaded_ff < n_eff) begin
                  cur_we    = 1'b1;
                  loaded_in = CNT_W'(loaded_ff + 1'b1);
               end
               if (req_tlast) begin
                  loaded_in   = '0;
                  idx_in      = '0;
                  conflict_in = 1'b0;
                  used_in     = '0;
                  state_in    = first_ff ? S_COPY_RD : S_SRCH_LD;
               end
            end
         end
         S_COPY_RD: begin
            cur_re   = 1'b1;
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            prev_we = 1'b1;
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               first_in = 1'b0;
               state_in = S_OUT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_COPY_RD;
            end
         end
         S_SRCH_LD: begin
            cur_re   = 1'b1;
            jdx_in   = '0;
            state_in = S_SRCH_GO;
         end
         S_SRCH_GO: begin
            prev_re    = 1'b1;
            prev_raddr = jdx_ff;
            rd_vld_in  = 1'b1;
            if (jdx_ff == last_idx) begin
               state_in = S_SRCH_DRAIN;
            end else begin
               jdx_in = jdx_ff + 1'b1;
            end
         end
         S_SRCH_DRAIN: begin
            if (dist_vld && (dist_tag == last_idx)) begin
               near_we          = 1'b1;
               conflict_in      = conflict_ff || used_ff[win_idx];
               used_in[win_idx] = 1'b1;
               if (idx_ff == last_idx) begin
                  idx_in   = '0;
                  state_in = S_UPD_RD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SRCH_LD;
               end
            end
         end
         S_UPD_RD: begin
            cur_re   = 1'b1;
            near_re  = 1'b1;
            state_in = S_UPD_SLOT;
         end
         S_UPD_SLOT: begin
            prev_re    = 1'b1;
            prev_raddr = near_rd_ff;
            state_in   = S_UPD_WR;
         end
         S_UPD_WR: begin
            // The write lands before the next slot read in S_UPD_SLOT, so a later
            // particle choosing the same slot sees this update.
            prev_we    = 1'b1;
            prev_waddr = near_rd_ff;
            prev_wdata = upd_item;
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               state_in = S_OUT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_OUT_RD: begin
            prev_re  = 1'b1;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (!rsp_vld_ff || rsp_tready) begin
               out_load    = 1'b1;
               rsp_data_in = {3'b000, conflict_ff,
                              orient_ff ? prev_rd_ff.angle : {ANGLE_W{1'b0}},
                              prev_rd_ff.y, prev_rd_ff.x, SLOT_W'(idx_ff)};
               rsp_last_in = (idx_ff == last_idx);
               if (idx_ff == last_idx) begin
                  idx_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end

      if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[2]))
            REG_PARTICLE_COUNT: begin
               count_in  = csr_pwdata[COUNT_W-1:0];
               first_in  = 1'b1;
               loaded_in = '0;
            end
            REG_ORIENTATION: begin
               orient_in = csr_pwdata[0];
            end
            default: begin
               orient_in = orient_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         jdx_ff      <= '0;
         loaded_ff   <= '0;
         first_ff    <= 1'b1;
         count_ff    <= COUNT_W'(1);
         orient_ff   <= 1'b0;
         conflict_ff <= 1'b0;
         used_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         jdx_ff      <= jdx_in;
         loaded_ff   <= loaded_in;
         first_ff    <= first_in;
         count_ff    <= count_in;
         orient_ff   <= orient_in;
         conflict_ff <= conflict_in;
         used_ff     <= used_in;
         rd_vld_ff   <= rd_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rd_tag_ff   <= rd_tag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (cur_re) begin
         cur_rd_ff <= cur_mem[cur_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (prev_re) begin
         prev_rd_ff <= prev_mem[prev_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (near_we) begin
         near_mem[idx_ff] <= near_wdata;
      end
      if (near_re) begin
         near_rd_ff <= near_mem[idx_ff];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= n_eff)
      else $error("frame fill count passed the particle count");

   a_dist_in_search: assert property (@(posedge clock) disable iff (reset)
      dist_vld |-> (state_ff == S_SRCH_GO || state_ff == S_SRCH_DRAIN))
      else $error("distance result outside the search phase");

   a_first_frame_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY_WR) |-> (!conflict_ff && (used_ff == '0)))
      else $error("conflict state set while storing a first frame");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_LD && out_load && idx_ff == last_idx) |=> req_tready)
      else $error("sequencer did not return to idle after the last slot");

endmodule

// ===== tb/nearest_neighbour_particle_matcher_tb.sv =====
`timescale 1ns / 1ps

module nearest_neighbour_particle_matcher_tb;
   import nnpm_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 64;
   localparam int PHASE_ITEMS   = 22;
   localparam int SLOT_DEPTH    = 16;
   localparam int FLIP_MIN      = 6434;
   localparam int PI_FIXED      = 12868;
   localparam int ANGLE_CEILING = 32767;

   typedef struct packed {
      logic [SLOT_W-1:0]         slot;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic signed [ANGLE_W-1:0] angle;
      logic                      conflict;
      logic                      last;
   } slot_report_type;

   typedef struct {
      bit              is_write;
      csr_reg_type     which;
      logic [31:0]     value;
      logic [15:0]     x;
      logic [15:0]     y;
      logic [15:0]     angle;
      logic            closes;
      bit              typed_valid;
      slot_report_type typed;
   } directed_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Tracker state as the block should hold it.
   bit [COUNT_W-1:0] count_reg = 1;
   bit               orient_reg = 0;
   bit [15:0]        cur_x[SLOT_DEPTH];
   bit [15:0]        cur_y[SLOT_DEPTH];
   int               cur_angle[SLOT_DEPTH];
   bit               cur_written[SLOT_DEPTH];
   bit [15:0]        prev_x[SLOT_DEPTH];
   bit [15:0]        prev_y[SLOT_DEPTH];
   int               prev_angle[SLOT_DEPTH];
   bit               first_frame = 1;
   int               loaded = 0;

   slot_report_type expected_reports[$];
   slot_report_type got_report;
   slot_report_type want_report;
   int              mismatches = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              phase_items = 0;

   int phase_counts[8] = '{3, 16, 31, 6, 0, 17, 2, 9};
   int phase_orient[8] = '{1, 0, 1, 1, 0, 1, 1, 0};

   directed_row_type directed_rows[17] = '{
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'hFFFF, 16'h0000, 16'h7FFF, 1'b1, 1'b1,
        '{4'd0, 16'hFFFF, 16'h0000, 16'sh0000, 1'b0, 1'b1}},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0000, 16'hFFFF, 16'h8000, 1'b1, 1'b1,
        '{4'd0, 16'h0000, 16'hFFFF, 16'sh0000, 1'b0, 1'b1}},
      '{1, REG_ORIENTATION, 32'd1, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, '0},
      '{1, REG_PARTICLE_COUNT, 32'd0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h1234, 16'h5678, 16'h8000, 1'b1, 1'b1,
        '{4'd0, 16'h1234, 16'h5678, 16'sh8000, 1'b0, 1'b1}},
      // A jump across the whole angle range flips and saturates at the top of the angle range.
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h1234, 16'h5678, 16'h7FFF, 1'b1, 1'b1,
        '{4'd0, 16'h1234, 16'h5678, 16'sh7FFF, 1'b0, 1'b1}},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h4321, 16'h8765, 16'h1000, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'hFFFE, 16'hFFFD, 16'hFFFC, 1'b1, 1'b0, '0},
      '{1, REG_PARTICLE_COUNT, 32'd3, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0100, 16'h0100, 16'h0000, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0300, 16'h0100, 16'h0000, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0800, 16'h0800, 16'h0000, 1'b1, 1'b0, '0},
      // Equidistant to slots 0 and 1; the angle step sits just below the flip.
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0200, 16'h0100, 16'h1921, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0310, 16'h0100, 16'h1922, 1'b0, 1'b0, '0},
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0300, 16'h0110, 16'hE6DE, 1'b1, 1'b0, '0},
      // Short frame: particles 1 and 2 keep their values from the frame before.
      '{0, REG_PARTICLE_COUNT, 32'd0, 16'h0801, 16'h0800, 16'h0000, 1'b1, 1'b0, '0}
   };

   nearest_neighbour_particle_matcher i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int frame_size();
      if (count_reg == 0) return 1;
      if (count_reg > SLOT_DEPTH) return SLOT_DEPTH;
      return count_reg;
   endfunction

   function automatic void track_request(input bit [15:0] x, input bit [15:0] y,
                                         input bit signed [15:0] angle, input bit closes,
                                         input bit queue_reports);
      int              n;
      int              s;
      int              a;
      int              diff;
      bit              conflict;
      int              pick[SLOT_DEPTH];
      longint          best;
      longint          sq_sum;
      longint          dx;
      longint          dy;
      slot_report_type r;
      n = frame_size();
      conflict = 0;
      if (loaded < n) begin
         cur_x[loaded] = x;
         cur_y[loaded] = y;
         cur_angle[loaded] = angle;
         cur_written[loaded] = 1;
         loaded++;
      end
      if (!closes) return;
      loaded = 0;
      if (first_frame) begin
         for (int i = 0; i < n; i++) begin
            prev_x[i] = cur_x[i];
            prev_y[i] = cur_y[i];
            prev_angle[i] = cur_angle[i];
         end
         first_frame = 0;
      end else begin
         for (int i = 0; i < n; i++) begin
            best = 0;
            pick[i] = 0;
            for (int j = 0; j < n; j++) begin
               dx = longint'(cur_x[i]) - longint'(prev_x[j]);
               dy = longint'(cur_y[i]) - longint'(prev_y[j]);
               sq_sum = dx * dx + dy * dy;
               if (j == 0 || sq_sum < best) begin
                  best = sq_sum;
                  pick[i] = j;
               end
            end
         end
         for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
               if (pick[i] == pick[j]) conflict = 1;
         // Slots are rewritten in particle order, so a later claim overwrites an earlier one.
         for (int i = 0; i < n; i++) begin
            s = pick[i];
            prev_x[s] = cur_x[i];
            prev_y[s] = cur_y[i];
            if (orient_reg) begin
               a = cur_angle[i];
               diff = prev_angle[s] - a;
               if (diff < 0) diff = -diff;
               if (diff >= FLIP_MIN) begin
                  a += PI_FIXED;
                  if (a > ANGLE_CEILING) a = ANGLE_CEILING;
               end
               prev_angle[s] = a;
            end
         end
      end
      if (queue_reports) begin
         for (int i = 0; i < n; i++) begin
            r.slot = i[SLOT_W-1:0];
            r.x = prev_x[i];
            r.y = prev_y[i];
            r.angle = orient_reg ? prev_angle[i][15:0] : '0;
            r.conflict = conflict;
            r.last = (i == n - 1);
            expected_reports.push_back(r);
         end
      end
   endfunction

   task automatic send_request(input bit [15:0] x, input bit [15:0] y, input bit [15:0] angle,
                               input bit closes, input bit typed_valid,
                               input slot_report_type typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {angle, y, x};
      req_tlast <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_request(x, y, angle, closes, !typed_valid);
      if (typed_valid) expected_reports.push_back(typed);
      phase_items++;
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type which, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (which == REG_PARTICLE_COUNT) begin
         count_reg = value[COUNT_W-1:0];
         first_frame = 1;
         loaded = 0;
      end else begin
         orient_reg = value[0];
      end
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_report.slot = rsp_tdata[3:0];
         got_report.x = rsp_tdata[19:4];
         got_report.y = rsp_tdata[35:20];
         got_report.angle = rsp_tdata[51:36];
         got_report.conflict = rsp_tdata[52];
         got_report.last = rsp_tlast;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected slot report: %p", got_report);
         end else begin
            want_report = expected_reports.pop_front();
            if (got_report !== want_report || rsp_tdata[55:53] !== 3'b000) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("slot report mismatch: expected %p, got %p (pad %b)",
                           want_report, got_report, rsp_tdata[55:53]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int        n;
      int        len;
      int        min_len;
      int        rot;
      int        s;
      int        frame_no;
      bit [15:0] x;
      bit [15:0] y;
      bit [15:0] angle;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < $size(directed_rows); k++) begin
         if (directed_rows[k].is_write) begin
            drain_reports();
            write_csr(directed_rows[k].which, directed_rows[k].value);
         end else begin
            send_request(directed_rows[k].x, directed_rows[k].y, directed_rows[k].angle,
                         directed_rows[k].closes, directed_rows[k].typed_valid,
                         directed_rows[k].typed);
         end
      end

      for (int p = 0; p < 8; p++) begin
         drain_reports();
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 67;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
            end
         endcase
         write_csr(REG_PARTICLE_COUNT, phase_counts[p]);
         write_csr(REG_ORIENTATION, phase_orient[p]);
         phase_items = 0;
         frame_no = 0;
         while (phase_items < PHASE_ITEMS) begin
            // Now and then the sender holds off until every slot report is back.
            if (frame_no == 1 || $urandom_range(7) == 0) drain_reports();
            n = frame_size();
            // A short frame may only leave out particles that an earlier frame wrote.
            min_len = n;
            while (min_len > 1 && cur_written[min_len-1]) min_len--;
            case ($urandom_range(9))
               0, 1: len = (min_len < n) ? $urandom_range(n - 1, min_len) : n;
               2: len = n + $urandom_range(3, 1);
               default: len = n;
            endcase
            rot = $urandom_range(n - 1);
            for (int i = 0; i < len; i++) begin
               s = ($urandom_range(4) == 0) ? $urandom_range(n - 1) : (i + rot) % n;
               if ($urandom_range(9) < 6) begin
                  x = prev_x[s] + 16'($urandom_range(64)) - 16'd32;
                  y = prev_y[s] + 16'($urandom_range(64)) - 16'd32;
                  angle = prev_angle[s][15:0] + 16'($urandom_range(18000)) - 16'd9000;
               end else begin
                  x = $urandom;
                  y = $urandom;
                  angle = $urandom;
               end
               send_request(x, y, angle, i == len - 1, 1'b0, '0);
            end
            frame_no++;
         end
      end

      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
